// File: rtl/lz78_pkg.sv
// ----------------------------------------------------------------------------
// lz78_pkg
// Shared codes and constants for the LZ78 dictionary find/insert core.
// ----------------------------------------------------------------------------
package lz78_pkg;

  localparam logic [1:0] CMD_FIND   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REINIT = 2'd2;

  localparam logic [2:0] REG_TABLE_SIZE   = 3'd0;
  localparam logic [2:0] REG_SYMBOL_COUNT = 3'd4;

  localparam logic [12:0] TABLE_SIZE_RST   = 13'd4096;
  localparam logic [8:0]  SYMBOL_COUNT_RST = 9'd256;
  localparam logic [8:0]  END_SYMBOL       = 9'd256;

  // lookup3 finaliser start value: base + (4 bytes << 2) + seed
  localparam logic [31:0] HASH_START = 32'hdeadbeef + 32'd16 + 32'd12345;
  localparam int          HASH_ROUNDS = 7;

endpackage

// File: rtl/lz78_req_if.sv
// ----------------------------------------------------------------------------
// lz78_req_if
// Request channel: command, parent code and next byte.
// ----------------------------------------------------------------------------
interface lz78_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] parent_code;
  logic [7:0]  next_byte;

  modport source (output valid, cmd, parent_code, next_byte, input ready);
  modport sink (input valid, cmd, parent_code, next_byte, output ready);
endinterface

// File: rtl/lz78_rsp_if.sv
// ----------------------------------------------------------------------------
// lz78_rsp_if
// Response channel: lookup / insert result.
// ----------------------------------------------------------------------------
interface lz78_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [11:0] code;
  logic        inserted;
  logic        full_res;

  modport source (output valid, found, code, inserted, full_res, input ready);
  modport sink (input valid, found, code, inserted, full_res, output ready);
endinterface

// File: rtl/lz78_ram.sv
// ----------------------------------------------------------------------------
// lz78_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lz78_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/lz78_dictionary_find_insert_core.sv
// ----------------------------------------------------------------------------
// lz78_dictionary_find_insert_core
// Hashed LZ78 dictionary: lookup, insert on miss, reinitialise.
// ----------------------------------------------------------------------------
// One request at a time. A find or insert is accepted, then runs the hash
// rounds (one shared xor/subtract/rotate unit), a bit-serial modulo of the
// 32-bit hash by the active table size, a read of the home slot and then of
// each chain entry walked in turn, a decide/store step on a miss, and when
// the lowest free slot is consumed a read/check scan of slots to find the
// next free one; then the result is posted, held back while the previous
// result beat is still held by the receiver. A reinitialise, and the start
// after reset, sweeps the whole node and chain-head memories, one slot per
// cycle, during which no request is taken (register writes still are).
module lz78_dictionary_find_insert_core #(
  parameter int TABLE_DEPTH = 4096,
  parameter int SYMBOL_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  lz78_req_if.sink    req,
  lz78_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW:0] RESET_SIZE =
    (TABLE_DEPTH < 4096) ? (AW+1)'(TABLE_DEPTH) : (AW+1)'(4096);
  localparam logic [8:0] SYM_MAX = 9'(1 << SYMBOL_BITS);

  typedef struct packed {
    logic          used;
    logic          root;
    logic [11:0]   parent;
    logic [8:0]    symbol;
    logic [AW-1:0] label;
    logic          link_v;
    logic [AW-1:0] link;
  } node_t;

  typedef struct packed {
    logic          v;
    logic [AW-1:0] ptr;
  } ptr_t;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_HASH     = 4'd2;
  localparam logic [3:0] S_DIV      = 4'd3;
  localparam logic [3:0] S_RDH      = 4'd4;
  localparam logic [3:0] S_CHKH     = 4'd5;
  localparam logic [3:0] S_CHKC     = 4'd6;
  localparam logic [3:0] S_MISS     = 4'd7;
  localparam logic [3:0] S_SCAN_RD  = 4'd8;
  localparam logic [3:0] S_SCAN_CHK = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  // configuration
  logic [12:0] table_size;
  logic [8:0]  symbol_count;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? 32'(symbol_count) : 32'(table_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size   <= lz78_pkg::TABLE_SIZE_RST;
      symbol_count <= lz78_pkg::SYMBOL_COUNT_RST;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        symbol_count <= pwdata[8:0];
      end else begin
        table_size <= pwdata[12:0];
      end
    end
  end

  // clipped register values, taken at reinitialise
  logic [8:0]  sym_clip;
  logic [16:0] size_clip;
  always_comb begin
    sym_clip  = (symbol_count > SYM_MAX) ? SYM_MAX : symbol_count;
    size_clip = 17'(table_size);
    if (size_clip > 17'(TABLE_DEPTH)) size_clip = 17'(TABLE_DEPTH);
    if (size_clip < 17'(sym_clip) + 17'd2) size_clip = 17'(sym_clip) + 17'd2;
  end

  logic [3:0]    state;
  logic [8:0]    act_sym;
  logic [AW:0]   act_size;
  logic [AW:0]   free_slot;
  logic [AW:0]   label_counter;
  logic [AW-1:0] clr_i;
  logic          clr_cmd;
  logic [1:0]    cmd;
  logic [11:0]   parent;
  logic [7:0]    sym;
  logic [31:0]   ha, hb, hc;
  logic [2:0]    round;
  logic [4:0]    div_cnt;
  logic [AW-1:0] rem;
  logic [AW-1:0] home;
  logic          home_used;
  ptr_t          head_save;
  logic [AW:0]   scan_i;
  logic          res_found;
  logic [11:0]   res_code;
  logic          res_ins;
  logic          out_valid;

  // memories
  logic          node_we, head_we;
  logic [AW-1:0] node_waddr, node_raddr, head_waddr;
  node_t         node_wdata, node_q;
  ptr_t          head_wdata, head_q;

  lz78_ram #(.WIDTH($bits(node_t)), .DEPTH(TABLE_DEPTH)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_q)
  );

  lz78_ram #(.WIDTH($bits(ptr_t)), .DEPTH(TABLE_DEPTH)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (home),
    .rdata (head_q)
  );

  // shared hash round unit: x = (x ^ y) - rotl(y, k)
  logic [31:0] rx, ry, rrot, rres;
  logic [4:0]  rk;
  always_comb begin
    case (round)
      3'd0:    begin rx = hc; ry = hb; rk = 5'd14; end
      3'd1:    begin rx = ha; ry = hc; rk = 5'd11; end
      3'd2:    begin rx = hb; ry = ha; rk = 5'd25; end
      3'd3:    begin rx = hc; ry = hb; rk = 5'd16; end
      3'd4:    begin rx = ha; ry = hc; rk = 5'd4;  end
      3'd5:    begin rx = hb; ry = ha; rk = 5'd14; end
      default: begin rx = hc; ry = hb; rk = 5'd24; end
    endcase
    rrot = (ry << rk) | (ry >> (6'd32 - {1'b0, rk}));
    rres = (rx ^ ry) - rrot;
  end

  // modulo step
  logic [AW:0] div_shift, div_rem;
  always_comb begin
    div_shift = {rem, hc[31]};
    div_rem   = (div_shift >= act_size) ? div_shift - act_size : div_shift;
  end

  function automatic logic node_hit(node_t n, logic [11:0] p, logic [7:0] s);
    return n.used && !n.root && n.parent == p && n.symbol == {1'b0, s};
  endfunction

  logic can_insert, pos_is_free;
  assign can_insert  = (cmd == lz78_pkg::CMD_INSERT) && (label_counter < act_size)
                       && (free_slot < act_size);
  assign pos_is_free = home_used || ({1'b0, home} == free_slot);

  // memory control
  always_comb begin
    node_we    = 1'b0;
    head_we    = 1'b0;
    node_waddr = clr_i;
    head_waddr = clr_i;
    node_wdata = '0;
    head_wdata = '0;
    node_raddr = home;
    case (state)
      S_CLEAR: begin
        node_we = 1'b1;
        head_we = 1'b1;
        if (clr_i < AW'(act_sym)) begin
          node_wdata.used   = 1'b1;
          node_wdata.root   = 1'b1;
          node_wdata.symbol = 9'(clr_i);
          node_wdata.label  = clr_i;
        end else if (clr_i == AW'(act_sym)) begin
          node_wdata.used   = 1'b1;
          node_wdata.root   = 1'b1;
          node_wdata.symbol = lz78_pkg::END_SYMBOL;
          node_wdata.label  = clr_i;
        end
      end
      S_CHKH:    node_raddr = head_q.ptr;
      S_CHKC:    node_raddr = node_q.link;
      S_SCAN_RD: node_raddr = scan_i[AW-1:0];
      S_MISS: begin
        if (can_insert) begin
          node_we           = 1'b1;
          node_wdata.used   = 1'b1;
          node_wdata.parent = parent;
          node_wdata.symbol = {1'b0, sym};
          node_wdata.label  = label_counter[AW-1:0];
          if (!home_used) begin
            node_waddr = home;
          end else begin
            node_waddr        = free_slot[AW-1:0];
            node_wdata.link_v = head_save.v;
            node_wdata.link   = head_save.ptr;
            head_we           = 1'b1;
            head_waddr        = home;
            head_wdata.v      = 1'b1;
            head_wdata.ptr    = free_slot[AW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_i     <= '0;
      clr_cmd   <= 1'b0;
      act_sym   <= SYM_MAX;
      act_size  <= RESET_SIZE;
      out_valid <= 1'b0;
    end else begin
      // the done state reloads the result beat itself
      if (out_valid && rsp.ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_i <= clr_i + 1'b1;
          if (clr_i == AW'(TABLE_DEPTH - 1)) begin
            free_slot     <= (AW+1)'(act_sym) + 1'b1;
            label_counter <= (AW+1)'(act_sym) + 1'b1;
            res_found     <= 1'b0;
            res_code      <= '0;
            res_ins       <= 1'b0;
            state         <= clr_cmd ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            cmd       <= req.cmd;
            parent    <= req.parent_code;
            sym       <= req.next_byte;
            res_found <= 1'b0;
            res_code  <= '0;
            res_ins   <= 1'b0;
            ha        <= lz78_pkg::HASH_START + 32'({req.parent_code, req.next_byte});
            hb        <= lz78_pkg::HASH_START;
            hc        <= lz78_pkg::HASH_START;
            round     <= '0;
            if (req.cmd == lz78_pkg::CMD_REINIT) begin
              act_sym  <= sym_clip;
              act_size <= (AW+1)'(size_clip);
              clr_i    <= '0;
              clr_cmd  <= 1'b1;
              state    <= S_CLEAR;
            end else if (req.cmd == lz78_pkg::CMD_FIND || req.cmd == lz78_pkg::CMD_INSERT) begin
              state <= S_HASH;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_HASH: begin
          case (round)
            3'd1, 3'd4: ha <= rres;
            3'd2, 3'd5: hb <= rres;
            default:    hc <= rres;
          endcase
          round <= round + 1'b1;
          if (round == 3'(lz78_pkg::HASH_ROUNDS - 1)) begin
            div_cnt <= '0;
            rem     <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= div_rem[AW-1:0];
          hc      <= {hc[30:0], 1'b0};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 5'd31) begin
            home  <= div_rem[AW-1:0];
            state <= S_RDH;
          end
        end
        S_RDH: state <= S_CHKH;
        S_CHKH: begin
          home_used <= node_q.used;
          head_save <= head_q;
          if (node_hit(node_q, parent, sym)) begin
            res_found <= 1'b1;
            res_code  <= 12'(node_q.label);
            state     <= S_DONE;
          end else begin
            state <= head_q.v ? S_CHKC : S_MISS;
          end
        end
        S_CHKC: begin
          if (node_hit(node_q, parent, sym)) begin
            res_found <= 1'b1;
            res_code  <= 12'(node_q.label);
            state     <= S_DONE;
          end else if (!node_q.link_v) begin
            state <= S_MISS;
          end
        end
        S_MISS: begin
          if (can_insert) begin
            res_code      <= 12'(label_counter);
            res_ins       <= 1'b1;
            label_counter <= label_counter + 1'b1;
            if (pos_is_free) begin
              scan_i <= free_slot + 1'b1;
              state  <= S_SCAN_RD;
            end else begin
              state <= S_DONE;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_SCAN_RD: begin
          if (scan_i >= act_size) begin
            free_slot <= scan_i;
            state     <= S_DONE;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (node_q.used) begin
            scan_i <= scan_i + 1'b1;
            state  <= S_SCAN_RD;
          end else begin
            free_slot <= scan_i;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid    <= 1'b1;
            rsp.found    <= res_found;
            rsp.code     <= res_code;
            rsp.inserted <= res_ins;
            rsp.full_res <= (label_counter >= act_size);
            clr_cmd      <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/lz78_checker.sv
// ----------------------------------------------------------------------------
// lz78_checker
// Port-level checks for the LZ78 dictionary core, bound into the core module.
// ----------------------------------------------------------------------------
module lz78_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_found,
  input logic [11:0] rsp_code,
  input logic        rsp_inserted
);

  // a held result beat stays up
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result beat dropped while stalled");

  // one request in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one in flight");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_found && rsp_inserted))
    else $error("found and inserted both set");

  a_miss_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found && !rsp_inserted |-> rsp_code == 12'd0)
    else $error("nonzero code on miss");

endmodule

bind lz78_dictionary_find_insert_core lz78_checker u_lz78_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_found    (rsp.found),
  .rsp_code     (rsp.code),
  .rsp_inserted (rsp.inserted)
);
